[hdl/assert_macros.svh]
// Assertion macros for the longest common substring block.
// Checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LCS_ASSERT(lbl, clk, rst_n, prop)
`define LCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/lcsl_pkg.sv]
// Package for the longest common substring block: sizes, cell command, saturation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lcsl_pkg;

  localparam int MAX_LEN = 256;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int OUT_W   = 9;
  localparam int OUT_CAP = 511;

  typedef enum logic {
    OP_STORED   = 1'b0,
    OP_STREAMED = 1'b1
  } op_t;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic             step;
    logic             drain;
    logic [LEN_W-1:0] idx;
    logic [LEN_W-1:0] len;
    logic [7:0]       ch;
  } cell_cmd_t;

  function automatic logic [OUT_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(OUT_CAP)) begin
      return OUT_W'(OUT_CAP);
    end
    return w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/lcsl_cell.sv]
// One cell of the chain: a stored character, its run length and a local maximum.
// Depends on lcsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lcsl_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lcsl_pkg::cell_cmd_t       cmd,
  input  wire logic [lcsl_pkg::LEN_W-1:0] cell_idx,
  input  wire logic [lcsl_pkg::LEN_W-1:0] left_run,
  input  wire logic [lcsl_pkg::LEN_W-1:0] left_max,
  output logic      [lcsl_pkg::LEN_W-1:0] run_o,
  output logic      [lcsl_pkg::LEN_W-1:0] max_o
);

  logic [7:0]                 stored_r;
  logic [lcsl_pkg::LEN_W-1:0] run_r, run_nxt;
  logic [lcsl_pkg::LEN_W-1:0] max_r, max_nxt;
  logic                       hit;

  assign hit = (cell_idx < cmd.len) && (stored_r == cmd.ch);

  always_comb begin
    run_nxt = run_r;
    max_nxt = max_r;
    if (cmd.clear) begin
      run_nxt = '0;
      max_nxt = '0;
    end else if (cmd.step) begin
      run_nxt = hit ? left_run + lcsl_pkg::LEN_W'(1) : '0;
      max_nxt = (run_nxt > max_r) ? run_nxt : max_r;
    end else if (cmd.drain) begin
      max_nxt = (left_max > max_r) ? left_max : max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      max_r <= '0;
    end else begin
      run_r <= run_nxt;
      max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.idx == cell_idx)) begin
      stored_r <= cmd.ch;
    end
  end

  assign run_o = run_r;
  assign max_o = max_r;

endmodule
`default_nettype wire

[hdl/lcsl_ctrl.sv]
// Sequencer: stored string bookkeeping, cell commands, max drain and result register.
// Depends on lcsl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lcsl_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_char,
  input  wire logic                       in_op,
  input  wire logic                       in_last,
  input  wire logic [lcsl_pkg::LEN_W-1:0] tail_max,
  output lcsl_pkg::cell_cmd_t             cmd,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [lcsl_pkg::OUT_W-1:0]      out_len,
  output logic                            out_ovf
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [lcsl_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [lcsl_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic                       closed_r, closed_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [lcsl_pkg::OUT_W-1:0] out_len_r;
  logic                       out_ovf_r;
  logic                       acc, capture, full;
  logic [lcsl_pkg::LEN_W-1:0] base;

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign base      = closed_r ? '0 : len_r;
  assign full      = (base == lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN));
  assign capture   = (state_r == ST_DRAIN)
                   && (cnt_r == lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN - 1))
                   && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    closed_nxt    = closed_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.idx       = base;
    cmd.len       = len_r;
    cmd.ch        = in_char;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == lcsl_pkg::OP_STORED) begin
            cmd.clear  = closed_r;
            cmd.load   = !full;
            len_nxt    = full ? base : base + lcsl_pkg::LEN_W'(1);
            ovf_nxt    = (ovf_r && !closed_r) || full;
            closed_nxt = in_last;
          end else begin
            cmd.step   = 1'b1;
            closed_nxt = 1'b1;
            if (in_last) begin
              state_nxt = ST_DRAIN;
              cnt_nxt   = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        cmd.drain = 1'b1;
        if (capture) begin
          cmd.clear     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (cnt_r != lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN - 1)) begin
          cnt_nxt = cnt_r + lcsl_pkg::LEN_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_len_r <= lcsl_pkg::sat_len(tail_max);
      out_ovf_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_len    = out_len_r;
  assign out_ovf    = out_ovf_r;

  `LCS_ASSERT(a_len_range, clk, rst_n, len_r <= lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN))
  `LCS_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= lcsl_pkg::LEN_W'(lcsl_pkg::MAX_LEN - 1))
  `LCS_ASSERT_NXT(a_last_drains, clk, rst_n, acc && in_op && in_last, state_r == ST_DRAIN)
  `LCS_ASSERT_NXT(a_capture_valid, clk, rst_n, capture, out_valid_r && closed_r)

endmodule
`default_nettype wire

[hdl/longest_common_substring_length.sv]
// Top level of the longest common substring length block: sequencer and cell chain.
// Depends on lcsl_pkg, lcsl_ctrl and lcsl_cell.
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | tdata[7:0] character, tuser op, tlast is_last
//  out_    | out | tvalid/tready      | tdata[8:0] match_length, tdata[9] overflow
//
// Each accepted request updates all cells of the chain at once; a new character is
// taken while idle. After a last streamed character the local maxima ripple along
// the chain during the drain state and the result is then registered, so the input
// stalls while draining, longer while an earlier result still waits.
// The result register frees the input side while a result waits on out_tready.
// Synchronous active-low reset; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module longest_common_substring_length (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  input  wire logic        in_tuser,   // op
  input  wire logic        in_tlast,   // is_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [8:0] match_length, [9] overflow, rest zero
);

  lcsl_pkg::cell_cmd_t        cmd;
  logic [lcsl_pkg::LEN_W-1:0] run_c [lcsl_pkg::MAX_LEN];
  logic [lcsl_pkg::LEN_W-1:0] max_c [lcsl_pkg::MAX_LEN];
  logic [lcsl_pkg::OUT_W-1:0] out_len;
  logic                       out_ovf;

  lcsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_char    (in_tdata),
    .in_op      (in_tuser),
    .in_last    (in_tlast),
    .tail_max   (max_c[lcsl_pkg::MAX_LEN-1]),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_len    (out_len),
    .out_ovf    (out_ovf)
  );

  for (genvar j = 0; j < lcsl_pkg::MAX_LEN; j++) begin : g_cell
    logic [lcsl_pkg::LEN_W-1:0] left_run;
    logic [lcsl_pkg::LEN_W-1:0] left_max;
    if (j == 0) begin : g_head
      assign left_run = '0;
      assign left_max = '0;
    end else begin : g_body
      assign left_run = run_c[j-1];
      assign left_max = max_c[j-1];
    end
    lcsl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cell_idx (lcsl_pkg::LEN_W'(j)),
      .left_run (left_run),
      .left_max (left_max),
      .run_o    (run_c[j]),
      .max_o    (max_c[j])
    );
  end

  assign out_tdata = {6'b0, out_ovf, out_len};

endmodule
`default_nettype wire

[sim/longest_common_substring_length_tb.sv]
// Testbench for longest_common_substring_length: drives stored and streamed strings,
// predicts each run length and overflow flag, and checks every result as it leaves.
// Depends on lcsl_pkg and the longest_common_substring_length RTL.
`timescale 1ns / 1ps
module longest_common_substring_length_tb;

  localparam int RANDOM_REQS    = 200;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [lcsl_pkg::OUT_W-1:0] length;
    logic                       overflow;
  } lcs_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // predictor state
  logic [7:0]                 held_chars [lcsl_pkg::MAX_LEN];
  logic [lcsl_pkg::LEN_W-1:0] held_len;
  bit                         held_closed;
  bit                         held_ovf;
  logic [lcsl_pkg::LEN_W-1:0] run_len [lcsl_pkg::MAX_LEN];
  logic [lcsl_pkg::LEN_W-1:0] best_len;
  lcs_result_t                pending_results[$];

  int  mismatches;
  int  results_predicted;
  int  sent_count;
  int  quiet_cycles;
  int  hold_reqs;
  int  hold_done;
  bit  idle_on;
  logic [7:0] alpha [4];
  int  alpha_n;

  longest_common_substring_length uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic void clear_runs();
    for (int k = 0; k < lcsl_pkg::MAX_LEN; k++) run_len[k] = '0;
    best_len = '0;
  endfunction

  function automatic void track_request(input lcsl_pkg::op_t op, input logic [7:0] ch,
                                        input logic is_last);
    lcs_result_t r;
    if (op == lcsl_pkg::OP_STORED) begin
      if (held_closed) begin
        held_len    = '0;
        held_closed = 1'b0;
        held_ovf    = 1'b0;
        clear_runs();
      end
      if (held_len < lcsl_pkg::MAX_LEN) begin
        held_chars[held_len] = ch;
        held_len++;
      end else begin
        held_ovf = 1'b1;
      end
      if (is_last) held_closed = 1'b1;
    end else begin
      held_closed = 1'b1;
      // descending, so cell k-1 still holds the previous row
      for (int k = int'(held_len) - 1; k >= 0; k--) begin
        if (held_chars[k] == ch) begin
          run_len[k] = ((k > 0) ? run_len[k-1] : '0) + 1'b1;
          if (run_len[k] > best_len) best_len = run_len[k];
        end else begin
          run_len[k] = '0;
        end
      end
      if (is_last) begin
        r.length   = (best_len > lcsl_pkg::OUT_CAP) ? lcsl_pkg::OUT_W'(lcsl_pkg::OUT_CAP)
                                                    : lcsl_pkg::OUT_W'(best_len);
        r.overflow = held_ovf;
        pending_results.push_back(r);
        results_predicted++;
        clear_runs();
      end
    end
  endfunction

  function automatic void log_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s mismatch: expected %0d, got %0d",
                                   $realtime, field, want, got);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic byte_q_t make_chars(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      if (alpha_n == 0) q.push_back(8'($urandom));
      else q.push_back(alpha[$urandom_range(0, alpha_n - 1)]);
    end
    return q;
  endfunction

  function automatic void pick_alphabet();
    alpha_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
  endfunction

  always @(posedge clk) begin : monitor
    lcs_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          log_mismatch("unexpected result", -1, int'(out_tdata[9:0]));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[8:0] !== want.length)
            log_mismatch("match_length", int'(want.length), int'(out_tdata[8:0]));
          if (out_tdata[9] !== want.overflow)
            log_mismatch("overflow", int'(want.overflow), int'(out_tdata[9]));
        end
      end
      if (in_tvalid && in_tready)
        track_request(lcsl_pkg::op_t'(in_tuser), in_tdata, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("longest_common_substring_length_tb: FAIL");
    $finish;
  end

  initial begin : rx_drive
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_req(input lcsl_pkg::op_t op, input logic [7:0] ch,
                          input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_run(input lcsl_pkg::op_t op, input byte_q_t chars, input bit close);
    for (int i = 0; i < chars.size(); i++)
      send_req(op, chars[i], close && (i == chars.size() - 1));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    // empty stored string straight after reset
    send_run(lcsl_pkg::OP_STREAMED, {8'h41}, 1'b1);
    send_run(lcsl_pkg::OP_STORED, {8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
    send_run(lcsl_pkg::OP_STREAMED, {8'hFF, 8'h00, 8'hFF}, 1'b1);
    // second streamed string against the same stored one
    send_run(lcsl_pkg::OP_STREAMED, {8'h01}, 1'b1);
    // stored string closed implicitly by a streamed request
    send_run(lcsl_pkg::OP_STORED, {8'h5A, 8'h5B}, 1'b0);
    send_run(lcsl_pkg::OP_STREAMED, {8'h5A, 8'h5B}, 1'b1);
    // new pair drops a streamed string in progress
    send_run(lcsl_pkg::OP_STORED, {8'hAA, 8'hBB, 8'hCC}, 1'b1);
    send_run(lcsl_pkg::OP_STREAMED, {8'hAA, 8'hBB}, 1'b0);
    send_run(lcsl_pkg::OP_STORED, {8'hBB, 8'hCC}, 1'b1);
    send_run(lcsl_pkg::OP_STREAMED, {8'hBB, 8'hCC}, 1'b1);
  endtask

  task automatic test_long_strings();
    byte_q_t stored;
    idle_on = 1'b1;
    alpha_n = 0;
    // one past capacity: truncated, match reaching the last cell
    stored = make_chars(lcsl_pkg::MAX_LEN + 1);
    send_run(lcsl_pkg::OP_STORED, stored, 1'b1);
    send_run(lcsl_pkg::OP_STREAMED,
             stored[lcsl_pkg::MAX_LEN-24:lcsl_pkg::MAX_LEN-1], 1'b1);
    send_run(lcsl_pkg::OP_STREAMED, stored[10:20], 1'b1);
  endtask

  task automatic test_backpressure();
    byte_q_t s;
    idle_on = 1'b0;
    alpha_n = 2;
    alpha[0] = 8'h30;
    alpha[1] = 8'h31;
    hold_reqs++;
    for (int p = 0; p < 6; p++) begin
      s = make_chars(3);
      send_run(lcsl_pkg::OP_STORED, s, 1'b1);
      send_run(lcsl_pkg::OP_STREAMED, make_chars(3), 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_random_pairs();
    byte_q_t stored;
    byte_q_t streamed;
    int kind, n, start, stop, reps, base;
    base = sent_count;
    while (sent_count - base < RANDOM_REQS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick_alphabet();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        stored = make_chars(n);
        send_run(lcsl_pkg::OP_STORED, stored, 1'b1);
        reps = $urandom_range(1, 3);
        for (int r = 0; r < reps; r++) begin
          if ($urandom_range(0, 2) == 0) begin
            start = $urandom_range(0, n - 1);
            stop = $urandom_range(start, n - 1);
            streamed = stored[start:stop];
            if ($urandom_range(0, 1) == 1) streamed.push_back(8'($urandom));
          end else begin
            streamed = make_chars($urandom_range(1, 16));
          end
          send_run(lcsl_pkg::OP_STREAMED, streamed, 1'b1);
        end
      end else if (kind == 7) begin
        send_run(lcsl_pkg::OP_STORED, make_chars($urandom_range(1, 8)), 1'b0);
        send_run(lcsl_pkg::OP_STREAMED, make_chars($urandom_range(1, 10)), 1'b1);
      end else if (kind == 8) begin
        send_run(lcsl_pkg::OP_STREAMED, make_chars($urandom_range(1, 6)), 1'b0);
      end else begin
        send_run(lcsl_pkg::OP_STREAMED, make_chars($urandom_range(1, 10)), 1'b1);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    idle_on   = 1'b0;
    held_len    = '0;
    held_closed = 1'b0;
    held_ovf    = 1'b0;
    for (int k = 0; k < lcsl_pkg::MAX_LEN; k++) held_chars[k] = '0;
    clear_runs();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_long_strings();
    test_backpressure();
    test_random_pairs();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("longest_common_substring_length_tb: PASS");
    end else begin
      $display("longest_common_substring_length_tb: FAIL");
    end
    $finish;
  end

endmodule

[longest_common_substring_length.f]
+incdir+hdl
hdl/lcsl_pkg.sv
hdl/lcsl_cell.sv
hdl/lcsl_ctrl.sv
hdl/longest_common_substring_length.sv
sim/longest_common_substring_length_tb.sv
